@@ src/damc_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// damc_pkg: shared types and constants of the decimal accumulator machine
// Holds the status and opcode encodings, field widths and the command and
// status bundles that join the controller to the datapath.
// ----------------------------------------------------------------------------
package damc_pkg;

    // Field widths.
    localparam int WORD_W  = 15;
    localparam int PC_W    = 7;
    localparam int ST_W    = 4;
    localparam int TDATA_W = 40;

    // Result status codes.
    localparam logic [ST_W-1:0] ST_OK         = 4'd0;
    localparam logic [ST_W-1:0] ST_WROTE      = 4'd1;
    localparam logic [ST_W-1:0] ST_HALTED     = 4'd2;
    localparam logic [ST_W-1:0] ST_OVERFLOW   = 4'd3;
    localparam logic [ST_W-1:0] ST_DIVZERO    = 4'd4;
    localparam logic [ST_W-1:0] ST_BADOP      = 4'd5;
    localparam logic [ST_W-1:0] ST_READRETRY  = 4'd6;
    localparam logic [ST_W-1:0] ST_STOPPED    = 4'd7;
    localparam logic [ST_W-1:0] ST_LOADED     = 4'd8;
    localparam logic [ST_W-1:0] ST_LOADREJECT = 4'd9;
    localparam logic [ST_W-1:0] ST_PCRANGE    = 4'd10;

    // Instruction opcodes (upper two decimal digits of a word).
    localparam logic [PC_W-1:0] OPC_READ     = 7'd10;
    localparam logic [PC_W-1:0] OPC_WRITE    = 7'd11;
    localparam logic [PC_W-1:0] OPC_LOAD     = 7'd20;
    localparam logic [PC_W-1:0] OPC_STORE    = 7'd21;
    localparam logic [PC_W-1:0] OPC_ADD      = 7'd30;
    localparam logic [PC_W-1:0] OPC_SUB      = 7'd31;
    localparam logic [PC_W-1:0] OPC_DIV      = 7'd32;
    localparam logic [PC_W-1:0] OPC_MUL      = 7'd33;
    localparam logic [PC_W-1:0] OPC_BRANCH   = 7'd40;
    localparam logic [PC_W-1:0] OPC_BRANCHN  = 7'd41;
    localparam logic [PC_W-1:0] OPC_BRANCHZ  = 7'd42;
    localparam logic [PC_W-1:0] OPC_HALT     = 7'd43;

    // Item kind carried on the input tuser bit.
    localparam logic OP_LOAD_ITEM = 1'b0;
    localparam logic OP_STEP_ITEM = 1'b1;

    // Value limits.
    localparam logic signed [29:0] WORD_MAX = 30'sd9999;
    localparam logic signed [29:0] LOAD_MAX = 30'sd9998;

    // Division by 100 through a reciprocal: q = (w * 5243) >> 19, exact for w < 43000.
    localparam int           RECIP       = 5243;
    localparam int           RECIP_SHIFT = 19;
    localparam int           DEC_PROD_W  = 27;
    localparam int           DEC_BASE    = 100;

    // Iterative divider on magnitudes up to 9999.
    localparam int DIV_BITS  = 14;
    localparam int DIV_CNT_W = 4;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;
        logic fetch;
        logic decode;
        logic oper;
        logic exec;
        logic div_step;
        logic finish;
    } dp_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic go_fetch;
        logic need_div;
        logic div_done;
        logic out_free;
    } dp_stat_t;

    // True when v lies within -lim..lim.
    function automatic logic in_range(input logic signed [29:0] v,
                                      input logic signed [29:0] lim);
        in_range = (v >= -lim) && (v <= lim);
    endfunction

endpackage
`default_nettype wire

@@ src/damc_ctrl.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// damc_ctrl: sequencing state machine
// Walks one item through fetch, decode and operand read (only for a step that runs),
// execute, the optional divide loop and the hand-off to the output register.
// ----------------------------------------------------------------------------
module damc_ctrl
    import damc_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_ready,
    input  wire dp_stat_t stat,
    output dp_cmd_t       cmd
);

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_FETCH  = 7'b0000010,
        S_DECODE = 7'b0000100,
        S_OPER   = 7'b0001000,
        S_EXEC   = 7'b0010000,
        S_DIV    = 7'b0100000,
        S_DONE   = 7'b1000000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next-state logic.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = stat.go_fetch ? S_FETCH : S_EXEC;
                end
            end
            S_FETCH:  state_next = S_DECODE;
            S_DECODE: state_next = S_OPER;
            S_OPER:   state_next = S_EXEC;
            S_EXEC:   state_next = stat.need_div ? S_DIV : S_DONE;
            S_DIV:
            begin
                if (stat.div_done)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (stat.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:  state_next = S_IDLE;
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd.take     = in_valid && (state_reg == S_IDLE);
        cmd.fetch    = (state_reg == S_FETCH);
        cmd.decode   = (state_reg == S_DECODE);
        cmd.oper     = (state_reg == S_OPER);
        cmd.exec     = (state_reg == S_EXEC);
        cmd.div_step = (state_reg == S_DIV);
        cmd.finish   = (state_reg == S_DONE) && stat.out_free;
    end

endmodule
`default_nettype wire

@@ src/damc_datapath.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// damc_datapath: word store, accumulator, counter and arithmetic
// Holds the word store with per-word valid bits, the machine registers, the
// decimal decoder, the iterative divider and the output register.
// ----------------------------------------------------------------------------
module damc_datapath
    import damc_pkg::*;
#(
    parameter int MEM_WORDS = 100
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire dp_cmd_t                   cmd,
    output dp_stat_t                       stat,
    input  wire logic                      in_op,
    input  wire logic [PC_W-1:0]           in_load_address,
    input  wire logic signed [WORD_W-1:0]  in_load_word,
    input  wire logic signed [WORD_W-1:0]  in_read_value,
    input  wire logic                      out_ready,
    output logic                           out_valid,
    output logic [ST_W-1:0]                out_status,
    output logic signed [WORD_W-1:0]       out_value,
    output logic [PC_W-1:0]                out_counter,
    output logic signed [WORD_W-1:0]       out_acc
);

    localparam int AW = $clog2(MEM_WORDS);

    // Word store and its valid bits; a word never written reads as zero.
    logic signed [WORD_W-1:0] mem [MEM_WORDS];
    logic [MEM_WORDS-1:0]     mem_valid_reg;
    logic signed [WORD_W-1:0] mem_q_reg;
    logic                     vld_q_reg;
    logic signed [WORD_W-1:0] rdata;
    logic [AW-1:0]            rd_addr;
    logic                     wr_en;
    logic [AW-1:0]            wr_addr;
    logic signed [WORD_W-1:0] wr_data;

    // Captured input item.
    logic                     op_reg;
    logic [PC_W-1:0]          la_reg;
    logic signed [WORD_W-1:0] lw_reg;
    logic signed [WORD_W-1:0] rv_reg;

    // Decoded instruction.
    logic signed [WORD_W-1:0] word_reg;
    logic [PC_W-1:0]          quo_reg;
    logic [PC_W-1:0]          addr_reg;
    logic [DEC_PROD_W-1:0]    dec_prod;
    logic [13:0]              addr_full;

    // Machine state.
    logic signed [WORD_W-1:0] acc_reg, acc_next;
    logic [PC_W-1:0]          pc_reg, pc_next;
    logic                     stopped_reg, stopped_next;
    logic [ST_W-1:0]          res_status_reg, res_status_next;
    logic signed [WORD_W-1:0] res_out_reg, res_out_next;
    logic                     pc_ok;

    // Arithmetic.
    logic signed [15:0]       sum;
    logic signed [15:0]       diff;
    logic signed [29:0]       prod;
    logic signed [WORD_W-1:0] acc_mag;
    logic signed [WORD_W-1:0] mem_mag;
    logic                     need_div;

    // Divider.
    logic [DIV_BITS-1:0]      dvd_reg;
    logic [DIV_BITS-1:0]      dvs_reg;
    logic [DIV_BITS:0]        rem_reg;
    logic [DIV_CNT_W-1:0]     div_cnt_reg;
    logic                     qneg_reg;
    logic [DIV_BITS:0]        rem_shift;
    logic                     rem_ge;
    logic                     div_done;
    logic signed [WORD_W-1:0] quot_val;

    // Output register.
    logic                     m_valid_reg;
    logic [ST_W-1:0]          m_status_reg;
    logic signed [WORD_W-1:0] m_value_reg;
    logic [PC_W-1:0]          m_counter_reg;
    logic signed [WORD_W-1:0] m_acc_reg;

    assign pc_ok = (pc_reg < PC_W'(MEM_WORDS));

    // Capture the accepted item.
    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            op_reg <= in_op;
            la_reg <= in_load_address;
            lw_reg <= in_load_word;
            rv_reg <= in_read_value;
        end
    end

    // Store read port: the counter during fetch, the operand address otherwise.
    assign addr_full = word_reg[13:0] - 14'(14'(quo_reg) * 14'(DEC_BASE));
    assign rd_addr   = cmd.fetch ? pc_reg[AW-1:0] : addr_full[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.fetch || cmd.oper)
        begin
            mem_q_reg <= mem[rd_addr];
        end
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mem_valid_reg <= '0;
            vld_q_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.fetch || cmd.oper)
            begin
                vld_q_reg <= mem_valid_reg[rd_addr];
            end
            if (wr_en)
            begin
                mem_valid_reg[wr_addr] <= 1'b1;
            end
        end
    end

    assign rdata = vld_q_reg ? mem_q_reg : '0;

    // Decimal split: opcode is word/100 by reciprocal, address follows in the next cycle.
    assign dec_prod = DEC_PROD_W'(rdata[13:0]) * DEC_PROD_W'(RECIP);

    always_ff @(posedge clk)
    begin
        if (cmd.decode)
        begin
            word_reg <= rdata;
            quo_reg  <= dec_prod[RECIP_SHIFT +: PC_W];
        end
        if (cmd.oper)
        begin
            addr_reg <= addr_full[PC_W-1:0];
        end
    end

    // Arithmetic on the accumulator and the operand word.
    assign sum     = 16'(acc_reg) + 16'(rdata);
    assign diff    = 16'(acc_reg) - 16'(rdata);
    assign prod    = 30'(acc_reg) * 30'(rdata);
    assign acc_mag = acc_reg[WORD_W-1] ? -acc_reg : acc_reg;
    assign mem_mag = rdata[WORD_W-1] ? -rdata : rdata;

    // Divider step: restoring, one quotient bit per cycle.
    assign rem_shift = {rem_reg[DIV_BITS-1:0], dvd_reg[DIV_BITS-1]};
    assign rem_ge    = (rem_shift >= {1'b0, dvs_reg});
    assign div_done  = (div_cnt_reg == DIV_CNT_W'(DIV_BITS));
    assign quot_val  = qneg_reg ? -WORD_W'({1'b0, dvd_reg}) : WORD_W'({1'b0, dvd_reg});

    always_ff @(posedge clk)
    begin
        if (cmd.exec && need_div)
        begin
            dvd_reg     <= acc_mag[DIV_BITS-1:0];
            dvs_reg     <= mem_mag[DIV_BITS-1:0];
            rem_reg     <= '0;
            div_cnt_reg <= '0;
            qneg_reg    <= acc_reg[WORD_W-1] ^ rdata[WORD_W-1];
        end
        else if (cmd.div_step && !div_done)
        begin
            rem_reg     <= rem_ge ? (rem_shift - {1'b0, dvs_reg}) : rem_shift;
            dvd_reg     <= {dvd_reg[DIV_BITS-2:0], rem_ge};
            div_cnt_reg <= div_cnt_reg + 1'b1;
        end
    end

    // Execute: machine state update for one item.
    always_comb
    begin
        acc_next        = acc_reg;
        pc_next         = pc_reg;
        stopped_next    = stopped_reg;
        res_status_next = res_status_reg;
        res_out_next    = res_out_reg;
        wr_en           = 1'b0;
        wr_addr         = addr_reg[AW-1:0];
        wr_data         = acc_reg;
        need_div        = 1'b0;
        if (cmd.exec)
        begin
            res_out_next = '0;
            priority if (op_reg == OP_LOAD_ITEM)
            begin
                if ((la_reg < PC_W'(MEM_WORDS)) && in_range(30'(lw_reg), LOAD_MAX))
                begin
                    wr_en           = 1'b1;
                    wr_addr         = la_reg[AW-1:0];
                    wr_data         = lw_reg;
                    res_status_next = ST_LOADED;
                end
                else
                begin
                    res_status_next = ST_LOADREJECT;
                end
            end
            else if (stopped_reg)
            begin
                res_status_next = ST_STOPPED;
            end
            else if (!pc_ok)
            begin
                stopped_next    = 1'b1;
                res_status_next = ST_PCRANGE;
            end
            else if (word_reg[WORD_W-1])
            begin
                // A negative word never decodes to a defined instruction.
                stopped_next    = 1'b1;
                res_status_next = ST_BADOP;
            end
            else
            begin
                res_status_next = ST_OK;
                unique case (quo_reg)
                    OPC_READ:
                    begin
                        if (in_range(30'(rv_reg), WORD_MAX))
                        begin
                            wr_en   = 1'b1;
                            wr_data = rv_reg;
                            pc_next = pc_reg + 1'b1;
                        end
                        else
                        begin
                            res_status_next = ST_READRETRY;
                        end
                    end
                    OPC_WRITE:
                    begin
                        res_out_next    = rdata;
                        res_status_next = ST_WROTE;
                        pc_next         = pc_reg + 1'b1;
                    end
                    OPC_LOAD:
                    begin
                        acc_next = rdata;
                        pc_next  = pc_reg + 1'b1;
                    end
                    OPC_STORE:
                    begin
                        wr_en   = 1'b1;
                        pc_next = pc_reg + 1'b1;
                    end
                    OPC_ADD:
                    begin
                        if (in_range(30'(sum), WORD_MAX))
                        begin
                            acc_next = sum[WORD_W-1:0];
                            pc_next  = pc_reg + 1'b1;
                        end
                        else
                        begin
                            stopped_next    = 1'b1;
                            res_status_next = ST_OVERFLOW;
                        end
                    end
                    OPC_SUB:
                    begin
                        if (in_range(30'(diff), WORD_MAX))
                        begin
                            acc_next = diff[WORD_W-1:0];
                            pc_next  = pc_reg + 1'b1;
                        end
                        else
                        begin
                            stopped_next    = 1'b1;
                            res_status_next = ST_OVERFLOW;
                        end
                    end
                    OPC_MUL:
                    begin
                        if (in_range(prod, WORD_MAX))
                        begin
                            acc_next = prod[WORD_W-1:0];
                            pc_next  = pc_reg + 1'b1;
                        end
                        else
                        begin
                            stopped_next    = 1'b1;
                            res_status_next = ST_OVERFLOW;
                        end
                    end
                    OPC_DIV:
                    begin
                        if (rdata == '0)
                        begin
                            stopped_next    = 1'b1;
                            res_status_next = ST_DIVZERO;
                        end
                        else
                        begin
                            need_div = 1'b1;
                        end
                    end
                    OPC_BRANCH:
                    begin
                        pc_next = addr_reg;
                    end
                    OPC_BRANCHN:
                    begin
                        pc_next = acc_reg[WORD_W-1] ? addr_reg : pc_reg + 1'b1;
                    end
                    OPC_BRANCHZ:
                    begin
                        pc_next = (acc_reg == '0) ? addr_reg : pc_reg + 1'b1;
                    end
                    OPC_HALT:
                    begin
                        stopped_next    = 1'b1;
                        res_status_next = ST_HALTED;
                    end
                    default:
                    begin
                        stopped_next    = 1'b1;
                        res_status_next = ST_BADOP;
                    end
                endcase
            end
        end
        else if (cmd.div_step && div_done)
        begin
            acc_next        = quot_val;
            pc_next         = pc_reg + 1'b1;
            res_status_next = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg     <= '0;
            pc_reg      <= '0;
            stopped_reg <= 1'b0;
        end
        else
        begin
            acc_reg     <= acc_next;
            pc_reg      <= pc_next;
            stopped_reg <= stopped_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_status_reg <= res_status_next;
        res_out_reg    <= res_out_next;
    end

    // Output register: loaded when the result is final, cleared on transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (cmd.finish)
        begin
            m_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            m_status_reg  <= res_status_reg;
            m_value_reg   <= res_out_reg;
            m_counter_reg <= pc_reg;
            m_acc_reg     <= acc_reg;
        end
    end

    assign out_valid   = m_valid_reg;
    assign out_status  = m_status_reg;
    assign out_value   = m_value_reg;
    assign out_counter = m_counter_reg;
    assign out_acc     = m_acc_reg;

    // Status to the controller.
    always_comb
    begin
        stat.go_fetch = (in_op == OP_STEP_ITEM) && !stopped_reg && pc_ok;
        stat.need_div = need_div;
        stat.div_done = div_done;
        stat.out_free = !m_valid_reg || out_ready;
    end

endmodule
`default_nettype wire

@@ src/decimal_accumulator_machine_core.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// decimal_accumulator_machine_core: accumulator machine on decimal words
// Input items either load one word of the 100-word store or execute one
// instruction; each item returns exactly one result item.
//
// Input channel s_axis: tuser is the item kind (0 load a word, 1 step).
// tdata carries the load address, the load word and the value for a read
// instruction. Output channel m_axis: tuser is the status code, tdata the
// written word, the counter and the accumulator after the item.
// One item is in work at a time. A load, or a step on a stopped machine or a
// counter past the store, goes straight from transfer in to execute and the
// output hand-off. A regular instruction takes one store read for the
// instruction word, a decode step, a second store read for the operand,
// execute and the output hand-off. A divide adds the one-bit-per-cycle
// divider loop before the hand-off. s_axis_tready rises in the same cycle the
// result turns valid, so the next item is taken while a result waits.
// Reset clears the store (per-word valid bits), accumulator, counter and the
// stopped flag at once; no clearing pass is needed. While the receiver
// stalls, the result is held and the next item stops before its output.
// ----------------------------------------------------------------------------
module decimal_accumulator_machine_core
    import damc_pkg::*;
#(
    parameter int MEM_WORDS = 100
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    // [6:0] load_address, [21:7] load_word, [36:22] read_value, [39:37] zero
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    // [0] op
    input  wire logic               s_axis_tuser,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    // [14:0] out_value, [21:15] next_counter, [36:22] acc_value, [39:37] zero
    output logic [TDATA_W-1:0]      m_axis_tdata,
    // [3:0] status
    output logic [ST_W-1:0]         m_axis_tuser
);

    dp_cmd_t                  cmd;
    dp_stat_t                 stat;
    logic signed [WORD_W-1:0] out_value;
    logic [PC_W-1:0]          out_counter;
    logic signed [WORD_W-1:0] out_acc;

    // Sequencer.
    damc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // Store, registers and arithmetic.
    damc_datapath #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_op           (s_axis_tuser),
        .in_load_address (s_axis_tdata[6:0]),
        .in_load_word    (s_axis_tdata[21:7]),
        .in_read_value   (s_axis_tdata[36:22]),
        .out_ready       (m_axis_tready),
        .out_valid       (m_axis_tvalid),
        .out_status      (m_axis_tuser),
        .out_value       (out_value),
        .out_counter     (out_counter),
        .out_acc         (out_acc)
    );

    // Pack the result fields.
    assign m_axis_tdata = {3'b000, out_acc, out_counter, out_value};

endmodule
`default_nettype wire

@@ src/damc_checker.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// damc_checker: port-level checks of the accumulator machine
// Watches the output channel for held results and consistent result fields.
// ----------------------------------------------------------------------------
module damc_checker
    import damc_pkg::*;
(
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               m_axis_tvalid,
    input wire logic               m_axis_tready,
    input wire logic [TDATA_W-1:0] m_axis_tdata,
    input wire logic [ST_W-1:0]    m_axis_tuser
);

    // No result is offered while reset is applied.
    a_reset_idle: assert property (@(posedge clk) !rst_n |-> !m_axis_tvalid)
        else $error("result offered during reset");

    // A stalled result holds still until its transfer.
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // Status is one of the defined codes.
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_PCRANGE)
        else $error("undefined status code");

    // Only a write instruction gives a nonzero output word.
    a_outval: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != ST_WROTE) |-> m_axis_tdata[14:0] == 15'd0)
        else $error("output word without a write instruction");

    // The counter never goes past one beyond the last store word.
    a_counter: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[21:15] <= 7'd100)
        else $error("counter out of range");

endmodule

bind decimal_accumulator_machine_core damc_checker u_damc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

@@ bench/damc_result_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// damc_result_checker: watches both channels of the accumulator machine
// Predicts the result of every input transfer from its own copy of the store,
// accumulator, counter and stopped flag, and compares each output transfer
// against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module damc_result_checker
    import damc_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_axis_tvalid,
    input  wire logic               s_axis_tready,
    input  wire logic [TDATA_W-1:0] s_axis_tdata,
    input  wire logic               s_axis_tuser,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata,
    input  wire logic [ST_W-1:0]    m_axis_tuser,
    output int                      fail_count,
    output int                      pending_results
);

    typedef struct packed {
        logic [ST_W-1:0]   status;
        logic [WORD_W-1:0] out_value;
        logic [PC_W-1:0]   next_counter;
        logic [WORD_W-1:0] acc_value;
    } machine_result_t;

    int          mem_words [100];
    int          accum;
    int          counter;
    bit          halted;
    machine_result_t expected_results[$];

    assign pending_results = expected_results.size();

    // Prints one mismatch line and counts it.
    task automatic report_mismatch(input string what, input int got, input int want);
        fail_count++;
        $display("ERROR %0t: %s got %0d expected %0d", $realtime, what, got, want);
    endtask

    // Executes one step of the machine on the model state; returns the status.
    function automatic logic [ST_W-1:0] execute_step(input int read_val, output int written);
        int word, code, addr, operand, r;
        written = 0;
        if (halted) return ST_STOPPED;
        if (counter >= 100)
        begin
            halted = 1;
            return ST_PCRANGE;
        end
        word = mem_words[counter];
        code = word / 100;
        addr = word % 100;
        if (addr < 0)
        begin
            halted = 1;
            return ST_BADOP;
        end
        operand = mem_words[addr];
        case (code)
            int'(OPC_READ):
            begin
                if (read_val < -9999 || read_val > 9999) return ST_READRETRY;
                mem_words[addr] = read_val;
                counter++;
                return ST_OK;
            end
            int'(OPC_WRITE):
            begin
                written = operand;
                counter++;
                return ST_WROTE;
            end
            int'(OPC_LOAD):
            begin
                accum = operand;
                counter++;
                return ST_OK;
            end
            int'(OPC_STORE):
            begin
                mem_words[addr] = accum;
                counter++;
                return ST_OK;
            end
            int'(OPC_ADD), int'(OPC_SUB), int'(OPC_MUL):
            begin
                if (code == int'(OPC_ADD)) r = accum + operand;
                else if (code == int'(OPC_SUB)) r = accum - operand;
                else r = accum * operand;
                if (r < -9999 || r > 9999)
                begin
                    halted = 1;
                    return ST_OVERFLOW;
                end
                accum = r;
                counter++;
                return ST_OK;
            end
            int'(OPC_DIV):
            begin
                if (operand == 0)
                begin
                    halted = 1;
                    return ST_DIVZERO;
                end
                accum = accum / operand;
                counter++;
                return ST_OK;
            end
            int'(OPC_BRANCH):
            begin
                counter = addr;
                return ST_OK;
            end
            int'(OPC_BRANCHN):
            begin
                if (accum < 0) counter = addr;
                else counter++;
                return ST_OK;
            end
            int'(OPC_BRANCHZ):
            begin
                if (accum == 0) counter = addr;
                else counter++;
                return ST_OK;
            end
            int'(OPC_HALT):
            begin
                halted = 1;
                return ST_HALTED;
            end
            default:
            begin
                halted = 1;
                return ST_BADOP;
            end
        endcase
    endfunction

    // Works out the result of one accepted input transfer.
    function automatic machine_result_t predict_result(input logic kind,
                                                       input logic [TDATA_W-1:0] data);
        machine_result_t res;
        int addr, word, written;
        addr    = int'(data[6:0]);
        word    = int'($signed(data[21:7]));
        written = 0;
        if (kind == OP_LOAD_ITEM)
        begin
            if (addr < 100 && word >= -9998 && word <= 9998)
            begin
                mem_words[addr] = word;
                res.status = ST_LOADED;
            end
            else
            begin
                res.status = ST_LOADREJECT;
            end
        end
        else
        begin
            res.status = execute_step(int'($signed(data[36:22])), written);
        end
        res.out_value    = WORD_W'(written);
        res.next_counter = PC_W'(counter);
        res.acc_value    = WORD_W'(accum);
        return res;
    endfunction

    // Reset state of the model.
    initial
    begin
        fail_count = 0;
        foreach (mem_words[i]) mem_words[i] = 0;
        accum   = 0;
        counter = 0;
        halted  = 0;
    end

    // Prediction on input transfers, comparison on output transfers.
    always @(posedge clk)
    begin
        machine_result_t got, want;
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
                expected_results.push_back(predict_result(s_axis_tuser, s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status       = m_axis_tuser;
                got.out_value    = m_axis_tdata[14:0];
                got.next_counter = m_axis_tdata[21:15];
                got.acc_value    = m_axis_tdata[36:22];
                if (expected_results.size() == 0)
                begin
                    report_mismatch("unexpected result, status", int'(got.status), -1);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status != want.status)
                        report_mismatch("status", int'(got.status), int'(want.status));
                    if (got.out_value != want.out_value)
                        report_mismatch("out_value", int'($signed(got.out_value)),
                                        int'($signed(want.out_value)));
                    if (got.next_counter != want.next_counter)
                        report_mismatch("next_counter", int'(got.next_counter),
                                        int'(want.next_counter));
                    if (got.acc_value != want.acc_value)
                        report_mismatch("acc_value", int'($signed(got.acc_value)),
                                        int'($signed(want.acc_value)));
                end
                if (m_axis_tdata[39:37] != 3'b000)
                    report_mismatch("tdata padding", int'(m_axis_tdata[39:37]), 0);
            end
        end
    end

endmodule

@@ bench/tb_decimal_accumulator_machine_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_decimal_accumulator_machine_core: stimulus and verdict for the machine
// Loads short random programs built from every opcode, runs them with step
// items and random read values, adds noise and edge cases, and varies idle
// and stall patterns on both channels. The checker does all comparison.
// ----------------------------------------------------------------------------
module tb_decimal_accumulator_machine_core;
    import damc_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    logic               clk;
    logic               rst_n;
    logic               s_axis_tvalid;
    logic               s_axis_tready;
    logic [TDATA_W-1:0] s_axis_tdata;
    logic               s_axis_tuser;
    logic               m_axis_tvalid;
    logic               m_axis_tready;
    logic [TDATA_W-1:0] m_axis_tdata;
    logic [ST_W-1:0]    m_axis_tuser;
    int                 fail_count;
    int                 pending_results;
    int                 send_idle_pct;
    int                 recv_stall_pct;
    int                 hold_off_cycles;
    int                 cycle_count = 0;

    decimal_accumulator_machine_core i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    damc_result_checker i_checker (
        .clk             (clk),
        .rst_n           (rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .m_axis_tuser    (m_axis_tuser),
        .fail_count      (fail_count),
        .pending_results (pending_results)
    );

    // Clock.
    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // Cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Receiver: random stalls, plus a long hold-off when requested.
    initial
    begin
        m_axis_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_off_cycles > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off_cycles--;
            end
            else
            begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // Offers one item and waits for its transfer. The valid stays high after
    // the transfer so that the next item can follow directly.
    task automatic send_item(input logic kind, input int addr, input int word,
                             input int read_val);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= {3'b000, WORD_W'(read_val), WORD_W'(word), PC_W'(addr)};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        @(negedge clk);
    endtask

    // Random value over the whole 15-bit field, or within the word range.
    function automatic int rand_word(input bit wide);
        if (wide) return int'($signed(15'($urandom)));
        case ($urandom_range(3))
            0: return int'($urandom_range(19998)) - 9999;
            1: return int'($urandom_range(200)) - 100;
            2: return int'($urandom_range(20)) - 10;
            default: return ($urandom_range(1) ? 9999 : -9999);
        endcase
    endfunction

    // Random instruction word; mostly valid opcodes with small addresses.
    function automatic int rand_instr(input int span);
        int codes[12] = '{10, 11, 20, 21, 30, 31, 32, 33, 40, 41, 42, 43};
        int code;
        if ($urandom_range(19) == 0) return int'($urandom_range(19996)) - 9998;
        code = codes[$urandom_range(11)];
        if (code == 43 && $urandom_range(2) != 0) code = 20;
        return code * 100 + int'($urandom_range(span - 1));
    endfunction

    // Loads a short program from address zero with a few data words after
    // it, then issues step items. Once the machine has stopped, the steps
    // only see the stopped status.
    task automatic run_program(input int span);
        int steps;
        for (int a = 0; a < span; a++)
            send_item(OP_LOAD_ITEM, a, rand_instr(span), 0);
        for (int a = span; a < span + 6; a++)
            send_item(OP_LOAD_ITEM, a, rand_word(0) % 9999, 0);
        steps = $urandom_range(4, 14);
        for (int k = 0; k < steps; k++)
            send_item(OP_STEP_ITEM, 0, 0,
                      ($urandom_range(9) == 0) ? rand_word(1) : rand_word(0));
    endtask

    // Stops offering items and waits until every expected result has come.
    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_results != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // Stimulus.
    initial
    begin
        rst_n           = 1'b0;
        s_axis_tvalid   = 1'b0;
        s_axis_tuser    = OP_LOAD_ITEM;
        s_axis_tdata    = '0;
        send_idle_pct   = 0;
        recv_stall_pct  = 0;
        hold_off_cycles = 0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: load edges and rejects, then a program using nine opcodes.
        send_item(OP_LOAD_ITEM, 99, 9998, 0);
        send_item(OP_LOAD_ITEM, 98, -9998, 0);
        send_item(OP_LOAD_ITEM, 97, 9999, 0);
        send_item(OP_LOAD_ITEM, 96, -9999, 0);
        send_item(OP_LOAD_ITEM, 100, 5, 0);
        send_item(OP_LOAD_ITEM, 127, -16384, 0);
        send_item(OP_LOAD_ITEM, 0, 1050, 0);
        send_item(OP_LOAD_ITEM, 1, 1150, 0);
        send_item(OP_LOAD_ITEM, 2, 2099, 0);
        send_item(OP_LOAD_ITEM, 3, 3099, 0);
        send_item(OP_LOAD_ITEM, 4, 3198, 0);
        send_item(OP_LOAD_ITEM, 5, 3350, 0);
        send_item(OP_LOAD_ITEM, 6, 3250, 0);
        send_item(OP_LOAD_ITEM, 7, 4109, 0);
        send_item(OP_LOAD_ITEM, 9, 4211, 0);
        send_item(OP_LOAD_ITEM, 10, 2151, 0);
        send_item(OP_LOAD_ITEM, 11, 3251, 0);
        send_item(OP_STEP_ITEM, 0, 0, 16383);
        send_item(OP_STEP_ITEM, 0, 0, -7);
        for (int k = 0; k < 8; k++)
            send_item(OP_STEP_ITEM, 0, 0, 0);
        send_item(OP_LOAD_ITEM, 0, 0, 0);
        wait_drained();

        // Random programs over the idling phases. The machine stops for good
        // once a program ends, so later steps mostly see the stopped status;
        // loads still vary the store contents.
        for (int phase = 0; phase < 4; phase++)
        begin
            send_idle_pct  = (phase == 1 || phase == 3) ? ((phase == 3) ? 9 : 53) : 0;
            recv_stall_pct = (phase == 2) ? 53 : ((phase == 3) ? 9 : 0);
            for (int p = 0; p < 6; p++)
                run_program($urandom_range(3, 12));
            for (int k = 0; k < 110; k++)
                send_item($urandom_range(1), $urandom_range(127), rand_word(1),
                          rand_word(1));
            if (phase == 1)
            begin
                hold_off_cycles = 300;
                for (int k = 0; k < 10; k++)
                    send_item(OP_LOAD_ITEM, $urandom_range(99), rand_word(0), 0);
            end
            wait_drained();
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

@@ decimal_accumulator_machine_core.f @@
src/damc_pkg.sv
src/damc_ctrl.sv
src/damc_datapath.sv
src/decimal_accumulator_machine_core.sv
src/damc_checker.sv
bench/damc_result_checker.sv
bench/tb_decimal_accumulator_machine_core.sv
